// ===== rtl/int64_to_decimal_ascii_top_defines.svh =====
// Assertion macros shared by the RTL files.
`ifndef INT64_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define INT64_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define I64D_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define I64D_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define I64D_ASSERT_IMP(label, ante, cons)
`define I64D_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== rtl/i64d_pkg.sv =====
package i64d_pkg;

  localparam logic [5:0] CHAR_MINUS   = 6'd45;
  localparam logic [1:0] CHAR_DIGIT_HI = 2'b11;

  typedef struct packed {
    logic valid;
    logic neg;
  } i64d_conv_t;

endpackage

// ===== rtl/int64_to_decimal_ascii_top.sv =====
// Signed integer to decimal text converter.
// The input channel (in_valid_i, in_stall_o, value_i) takes one word per number.
// Only the low VALUE_WIDTH bits of value_i are used, read as two's complement.
// The output channel (out_valid_o, out_stall_i) gives one character per word:
// ascii_char_o is '-' or a digit, and last_char_o marks the final character.
// A negative number starts with '-'; zero gives the single character '0'.
// The magnitude is converted by shift-and-add-three, one bit per cycle. It then
// moves to the character sequencer, which drops one leading zero per cycle and
// sends one character per cycle while out_stall_i is low. The converter takes
// the next number while the sequencer is still sending.
// When out_stall_i is high and out_valid_o is high, the output word holds and
// the sequencer waits; the converter finishes its number and then stalls the
// input until handoff.
// Reset clears all control state; no number is in flight afterwards.
module int64_to_decimal_ascii_top import i64d_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  ascii_char_o,
  output logic        last_char_o
);

  // Decimal digits of 2^(VALUE_WIDTH-1), the largest magnitude.
  localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;

  i64d_conv_t                conv;
  logic [NUM_DIGITS*4-1:0]   bcd;
  logic                      take;
  logic                      stall;

  assign in_stall_o = stall;

  i64d_dabble #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .NUM_DIGITS (NUM_DIGITS)
  ) u_dabble (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_valid_i && !stall),
    .raw_i  (value_i[VALUE_WIDTH-1:0]),
    .take_i (take),
    .stall_o(stall),
    .conv_o (conv),
    .bcd_o  (bcd)
  );

  i64d_emit #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .conv_i      (conv),
    .bcd_i       (bcd),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ascii_char_o(ascii_char_o),
    .last_char_o (last_char_o)
  );

endmodule

// ===== rtl/i64d_dabble.sv =====
`include "int64_to_decimal_ascii_top_defines.svh"

module i64d_dabble import i64d_pkg::*; #(
  parameter int VALUE_WIDTH = 64,
  parameter int NUM_DIGITS  = 19
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [VALUE_WIDTH-1:0]  raw_i,
  input  logic                    take_i,
  output logic                    stall_o,
  output i64d_conv_t              conv_o,
  output logic [NUM_DIGITS*4-1:0] bcd_o
);

  localparam int BW = NUM_DIGITS * 4;
  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic                   neg_q, neg_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [BW-1:0]          bcd_q, bcd_d;
  logic [BW-1:0]          bcd_adj;
  logic                   bcd_ok;
  logic                   raw_neg;

  assign raw_neg = raw_i[VALUE_WIDTH-1];
  assign stall_o = busy_q || (done_q && !take_i);
  assign conv_o  = '{valid: done_q, neg: neg_q};
  assign bcd_o   = bcd_q;

  // Add three to every digit of five or more before each doubling.
  always_comb begin
    logic [3:0] dig;
    dig = '0;
    bcd_ok = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dig = bcd_q[i*4 +: 4];
      bcd_adj[i*4 +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
      if (dig > 4'd9) begin
        bcd_ok = 1'b0;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    bcd_d  = bcd_q;
    if (done_q && take_i) begin
      done_d = 1'b0;
    end
    if (busy_q) begin
      bcd_d = {bcd_adj[BW-2:0], mag_q[VALUE_WIDTH-1]};
      mag_d = {mag_q[VALUE_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      neg_d  = raw_neg;
      mag_d  = raw_neg ? (~raw_i + VALUE_WIDTH'(1)) : raw_i;
      bcd_d  = '0;
      cnt_d  = CW'(VALUE_WIDTH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    bcd_q <= bcd_d;
  end

  `I64D_ASSERT_IMP(a_busy_cnt, busy_q, cnt_q != '0)
  `I64D_ASSERT_IMP(a_done_idle, done_q, !busy_q)
  `I64D_ASSERT_IMP(a_done_bcd, done_q, bcd_ok)

endmodule

// ===== rtl/i64d_emit.sv =====
`include "int64_to_decimal_ascii_top_defines.svh"

module i64d_emit import i64d_pkg::*; #(
  parameter int NUM_DIGITS = 19
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  i64d_conv_t              conv_i,
  input  logic [NUM_DIGITS*4-1:0] bcd_i,
  output logic                    take_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [5:0]              ascii_char_o,
  output logic                    last_char_o
);

  localparam int BW = NUM_DIGITS * 4;
  localparam int LW = $clog2(NUM_DIGITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_DIG  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [LW-1:0] left_q, left_d;
  logic [BW-1:0] bcd_q, bcd_d;
  logic          neg_q, neg_d;
  logic          oval_q, oval_d;
  logic [5:0]    char_q, char_d;
  logic          last_q, last_d;
  logic          out_free;
  logic [3:0]    top_dig;

  assign take_o       = (state_q == ST_IDLE);
  assign out_free     = !oval_q || !out_stall_i;
  assign top_dig      = bcd_q[BW-1 -: 4];
  assign out_valid_o  = oval_q;
  assign ascii_char_o = char_q;
  assign last_char_o  = last_q;

  always_comb begin
    state_d = state_q;
    left_d  = left_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    char_d  = char_q;
    last_d  = last_q;
    oval_d  = out_free ? 1'b0 : oval_q;
    case (state_q)
      ST_IDLE: begin
        if (conv_i.valid) begin
          bcd_d   = bcd_i;
          neg_d   = conv_i.neg;
          left_d  = LW'(NUM_DIGITS);
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Leading zeros are dropped, but the units digit always remains.
        if (top_dig == 4'd0 && left_q > LW'(1)) begin
          bcd_d  = {bcd_q[BW-5:0], 4'd0};
          left_d = left_q - LW'(1);
        end else begin
          state_d = neg_q ? ST_SIGN : ST_DIG;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          oval_d  = 1'b1;
          char_d  = CHAR_MINUS;
          last_d  = 1'b0;
          state_d = ST_DIG;
        end
      end
      ST_DIG: begin
        if (out_free) begin
          oval_d = 1'b1;
          char_d = {CHAR_DIGIT_HI, top_dig};
          last_d = (left_q == LW'(1));
          bcd_d  = {bcd_q[BW-5:0], 4'd0};
          left_d = left_q - LW'(1);
          if (left_q == LW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      left_q  <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      left_q  <= left_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  `I64D_ASSERT_IMP(a_dig_left, state_q == ST_DIG, left_q != '0)
  `I64D_ASSERT_IMP(a_skip_left, state_q == ST_SKIP, left_q != '0)
  `I64D_ASSERT_NXT(a_take_busy, state_q == ST_IDLE && conv_i.valid, state_q == ST_SKIP)

endmodule
